@@ src/iir_direct_form_filter_macros.svh @@
// Assertion macros for the IIR direct-form filter.
// Used by iir_direct_form_filter.sv; expand to nothing when SYNTHESIS is defined.
`ifndef IIR_DIRECT_FORM_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_MACROS_SVH

`ifndef SYNTHESIS

`define IIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define IIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define IIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/iir_pkg.sv @@
// Package for the IIR direct-form filter: widths, types, register indexes.
// No dependencies.
`default_nettype none

package iir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_FRAC = 20;
    localparam int MAX_ORDER = 3;
    localparam int HIST_FRAC = 8;
    localparam int COEF_W    = 24;
    localparam int HIST_W    = SAMPLE_W + HIST_FRAC;
    localparam int ORDER_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_FULL  = SAMPLE_W + COEF_W + HIST_FRAC + 3;
    localparam int ACC_W     = (ACC_FULL > 64) ? 64 : ACC_FULL;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER,
        REG_A0,
        REG_A1,
        REG_A2,
        REG_A3,
        REG_B1,
        REG_B2,
        REG_B3
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [HIST_W-1:0]   hist_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

`default_nettype wire

@@ src/iir_direct_form_filter.sv @@
// Top level of the IIR direct-form I filter, order 0 to 3.
// Depends on iir_pkg and iir_direct_form_filter_macros.svh.
//
// Usage:
//   Input channel s_valid/s_ready carries one signed sample per item; the
//   result channel m_valid/m_ready carries the filtered sample and a clip flag.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   index 0 is the order, 1..4 are a0..a3, 5..7 are b1..b3 (Q3.20).
//   Write configuration only while no item is in flight.
// Timing:
//   An accepted item waits in the input register, then goes to the result
//   register on m_. One item per cycle is sustained while m_ready is high;
//   the limit is the output-history recurrence, closed through the parallel
//   multipliers and the adder tree between the input and result registers.
// Reset:
//   aresetn low clears both histories, all coefficients, the order (bypass)
//   and both valid flags.
// Stall:
//   While m_ready is low one item waits in the result register and one more
//   in the input register; s_ready then drops and nothing is lost.
`default_nettype none

`include "iir_direct_form_filter_macros.svh"

module iir_direct_form_filter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [iir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [iir_pkg::COEF_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [iir_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [iir_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_clipped
);
    import iir_pkg::*;

    localparam int OUT_SHIFT = COEF_FRAC + HIST_FRAC;

    logic [ORDER_W-1:0] order_reg;
    coef_t              coef_a_reg [0:MAX_ORDER];
    coef_t              coef_b_reg [1:MAX_ORDER];

    sample_t in_hist_reg  [0:MAX_ORDER-1];
    hist_t   out_hist_reg [0:MAX_ORDER-1];

    logic    in_valid_reg, in_valid_next;
    sample_t x_reg, x_next;
    logic    out_valid_reg, out_valid_next;
    sample_t y_out_reg, y_out_next;
    logic    clip_reg, clip_next;

    logic               fire;
    logic [ORDER_W-1:0] order_eff;

    sample_t tap_x [0:MAX_ORDER];
    logic signed [SAMPLE_W+COEF_W-1:0] ff_prod [0:MAX_ORDER];
    logic signed [HIST_W+COEF_W-1:0]   fb_prod [1:MAX_ORDER];
    acc_t acc;

    logic signed [ACC_W:0] hist_rnd;
    logic signed [ACC_W:0] out_rnd;
    logic                  hist_ovf, out_ovf;
    hist_t                 y_hist;

    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign order_eff = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;

    always_comb begin
        tap_x[0] = x_reg;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            tap_x[k] = in_hist_reg[k-1];
        end
        for (int k = 0; k <= MAX_ORDER; k++) begin
            ff_prod[k] = tap_x[k] * coef_a_reg[k];
        end
        for (int k = 1; k <= MAX_ORDER; k++) begin
            fb_prod[k] = out_hist_reg[k-1] * coef_b_reg[k];
        end
    end

    always_comb begin
        acc = ACC_W'(ff_prod[0]) <<< HIST_FRAC;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            if (k <= int'(order_eff)) begin
                acc = acc + (ACC_W'(ff_prod[k]) <<< HIST_FRAC) - ACC_W'(fb_prod[k]);
            end
        end
    end

    always_comb begin
        hist_rnd = ($signed({acc[ACC_W-1], acc}) >>> COEF_FRAC)
                 + $signed({{ACC_W{1'b0}}, acc[COEF_FRAC-1]});
        out_rnd  = ($signed({acc[ACC_W-1], acc}) >>> OUT_SHIFT)
                 + $signed({{ACC_W{1'b0}}, acc[OUT_SHIFT-1]});
        hist_ovf = !((&hist_rnd[ACC_W:HIST_W-1]) || !(|hist_rnd[ACC_W:HIST_W-1]));
        out_ovf  = !((&out_rnd[ACC_W:SAMPLE_W-1]) || !(|out_rnd[ACC_W:SAMPLE_W-1]));
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        y_out_next     = y_out_reg;
        clip_next      = clip_reg;
        y_hist         = hist_rnd[HIST_W-1:0];

        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            x_next        = s_sample_in;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (order_eff == '0) begin
            y_hist = {x_reg, {HIST_FRAC{1'b0}}};
        end else if (hist_ovf) begin
            y_hist = hist_rnd[ACC_W] ? {1'b1, {(HIST_W-1){1'b0}}}
                                     : {1'b0, {(HIST_W-1){1'b1}}};
        end

        if (fire) begin
            out_valid_next = 1'b1;
            if (order_eff == '0) begin
                y_out_next = x_reg;
                clip_next  = 1'b0;
            end else begin
                y_out_next = out_rnd[SAMPLE_W-1:0];
                if (out_ovf) begin
                    y_out_next = out_rnd[ACC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
                end
                clip_next = hist_ovf || out_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_out_reg <= y_out_next;
        clip_reg  <= clip_next;
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            order_reg     <= '0;
            for (int k = 0; k <= MAX_ORDER; k++) begin
                coef_a_reg[k] <= '0;
            end
            for (int k = 1; k <= MAX_ORDER; k++) begin
                coef_b_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_ORDER; k++) begin
                in_hist_reg[k]  <= '0;
                out_hist_reg[k] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_ORDER) begin
                order_reg <= cfg_data[ORDER_W-1:0];
            end
            for (int k = 0; k <= MAX_ORDER; k++) begin
                if (cfg_we && int'(cfg_index) == int'(REG_A0) + k) begin
                    coef_a_reg[k] <= cfg_data;
                end
            end
            for (int k = 1; k <= MAX_ORDER; k++) begin
                if (cfg_we && int'(cfg_index) == int'(REG_B1) + k - 1) begin
                    coef_b_reg[k] <= cfg_data;
                end
            end
            if (fire) begin
                in_hist_reg[0]  <= x_reg;
                out_hist_reg[0] <= y_hist;
                for (int k = 1; k < MAX_ORDER; k++) begin
                    in_hist_reg[k]  <= in_hist_reg[k-1];
                    out_hist_reg[k] <= out_hist_reg[k-1];
                end
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = y_out_reg;
    assign m_clipped    = clip_reg;

    `IIR_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready, "input stalled without a full pipe")

    `IIR_ASSERT_NEXT(a_fire_valid, aclk, aresetn, fire,
        m_valid && in_hist_reg[0] == $past(x_reg), "item lost or history not advanced")

    `IIR_ASSERT_NEXT(a_bypass, aclk, aresetn, fire && order_eff == '0,
        !m_clipped && m_sample_out == $past(x_reg), "bypass result differs from sample")

    `IIR_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid_reg && !m_ready && !fire,
        m_valid && $stable(y_out_reg) && $stable(clip_reg), "stalled result changed")

endmodule

`default_nettype wire
